// ===== sv/ftfi_pkg.sv =====
// Shared types, constants and helpers for the FIR-then-recursive filter.
`default_nettype none
package ftfi_pkg;

	// Defaults for the top-level parameters
	localparam int TAP_COUNT_DEF    = 4;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// Field and register widths
	localparam int COEF_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int OUT_W      = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Fixed-point scaling
	localparam int FIR_SHIFT = 12;
	localparam int IIR_SHIFT = 15;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIR_COEF_0       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IIR_INPUT_GAIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IIR_FEEDBACK_GAIN = 3'd5;
	localparam int NUM_COEF_REGS = 4;

	// Reset values
	localparam logic signed [COEF_W-1:0] COEF_ONE     = 16'sd4096;
	localparam logic signed [GAIN_W-1:0] GAIN_A_RESET = 16'sd22938;
	localparam logic signed [GAIN_W-1:0] GAIN_G_RESET = 16'sd9830;

	// Output clamp limits
	localparam logic signed [63:0] OUT_MAX = 64'sd524287;
	localparam logic signed [63:0] OUT_MIN = -64'sd524288;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One configuration write
	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_write_t;

	// Clamp a sign-extended value to the signed output range
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > OUT_MAX) begin
			r = OUT_MAX[OUT_W-1:0];
		end else if (v < OUT_MIN) begin
			r = OUT_MIN[OUT_W-1:0];
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/ftfi_stream_if.sv =====
// Valid/ready stream interfaces for the input and output samples.
`default_nettype none
interface ftfi_in_if #(
	parameter int SAMPLE_WIDTH = ftfi_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface ftfi_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [ftfi_pkg::OUT_W-1:0]  sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

// ===== sv/ftfi_queue.sv =====
// Small register queue that decouples the FIR front from the recursive back.
`default_nettype none
module ftfi_queue #(
	parameter int WIDTH = ftfi_pkg::OUT_W,
	parameter int DEPTH = ftfi_pkg::QDEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire logic [WIDTH-1:0]             push_data,
	input  wire logic                         pop,
	output logic      [WIDTH-1:0]             pop_data,
	output logic                              not_empty,
	output logic      [$clog2(DEPTH+1)-1:0]   count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign pop_data  = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/ftfi_fir.sv =====
// Front part: accepts samples, keeps the tap window and computes the FIR value.
`default_nettype none
module ftfi_fir #(
	parameter int TAP_COUNT    = ftfi_pkg::TAP_COUNT_DEF,
	parameter int SAMPLE_WIDTH = ftfi_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ftfi_pkg::cfg_write_t               cfg,
	ftfi_in_if.sink                                 raw,
	input  wire logic [ftfi_pkg::QCNT_W-1:0]        q_count,
	output logic                                    push,
	output logic signed [ftfi_pkg::OUT_W-1:0]       push_data
);
	localparam int PROD_W = SAMPLE_WIDTH + ftfi_pkg::COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT + 1);
	localparam int PEND_W = ftfi_pkg::QCNT_W + 1;

	logic signed [ftfi_pkg::COEF_W-1:0] coef_q [TAP_COUNT];
	logic signed [SAMPLE_WIDTH-1:0]     hist_q [TAP_COUNT];
	logic                               v_s1;
	logic signed [PROD_W-1:0]           prod_s2 [TAP_COUNT];
	logic                               v_s2;
	logic [PEND_W-1:0]                  pending;
	logic                               accept;
	logic signed [ACC_W-1:0]            acc;

	// Reserve a queue slot for every item in flight
	assign pending = {1'b0, q_count} + PEND_W'(v_s1) + PEND_W'(v_s2);
	assign raw.ready = (pending < PEND_W'(ftfi_pkg::QDEPTH));
	assign accept    = raw.valid && raw.ready;

	// Hold the tap weights; taps past the register list keep unity weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAP_COUNT; i++) begin
				coef_q[i] <= ftfi_pkg::COEF_ONE;
			end
		end else if (cfg.we) begin
			for (int i = 0; i < TAP_COUNT; i++) begin
				if (i < ftfi_pkg::NUM_COEF_REGS &&
				    cfg.index == ftfi_pkg::REG_FIR_COEF_0 + ftfi_pkg::CFG_IDX_W'(i)) begin
					coef_q[i] <= cfg.data;
				end
			end
		end
	end

	// Shift the new sample into the tap window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAP_COUNT; i++) begin
				hist_q[i] <= '0;
			end
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				hist_q[0] <= raw.sample_in;
				for (int i = 1; i < TAP_COUNT; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
			end
		end
	end

	// Register one product per tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int i = 0; i < TAP_COUNT; i++) begin
				prod_s2[i] <= PROD_W'(coef_q[i]) * PROD_W'(hist_q[i]);
			end
		end
	end

	// Sum the products, scale down and clamp into the queue
	always_comb begin
		acc = '0;
		for (int i = 0; i < TAP_COUNT; i++) begin
			acc = acc + ACC_W'(prod_s2[i]);
		end
	end

	assign push      = v_s2;
	assign push_data = ftfi_pkg::sat_out(64'(acc >>> ftfi_pkg::FIR_SHIFT));
endmodule
`default_nettype wire

// ===== sv/ftfi_iir.sv =====
// Back part: first-order recursive stage and the output register.
`default_nettype none
module ftfi_iir (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ftfi_pkg::cfg_write_t               cfg,
	input  wire logic                               q_valid,
	input  wire logic [ftfi_pkg::OUT_W-1:0]         q_data,
	output logic                                    pop,
	ftfi_out_if.source                              filtered
);
	localparam int PROD_W = ftfi_pkg::GAIN_W + ftfi_pkg::OUT_W;
	localparam int SUM_W  = PROD_W + 1;

	logic signed [ftfi_pkg::GAIN_W-1:0] gain_a_q;
	logic signed [ftfi_pkg::GAIN_W-1:0] gain_g_q;
	logic signed [ftfi_pkg::OUT_W-1:0]  y_q;
	logic signed [PROD_W-1:0]           pa_s1;
	logic signed [PROD_W-1:0]           pg_s1;
	logic                               v_s1;
	logic                               advance;
	logic signed [SUM_W-1:0]            sum;
	logic signed [ftfi_pkg::OUT_W-1:0]  y_next;

	// Hold the recursive gains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_a_q <= ftfi_pkg::GAIN_A_RESET;
			gain_g_q <= ftfi_pkg::GAIN_G_RESET;
		end else if (cfg.we) begin
			case (cfg.index)
				ftfi_pkg::REG_IIR_INPUT_GAIN:    gain_a_q <= cfg.data;
				ftfi_pkg::REG_IIR_FEEDBACK_GAIN: gain_g_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Take one item only after the previous output has been stored
	assign pop     = q_valid && !v_s1;
	assign advance = v_s1 && (!filtered.valid || filtered.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pop) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	// Register both products
	always_ff @(posedge clk) begin
		if (pop) begin
			pa_s1 <= PROD_W'(gain_a_q) * PROD_W'(signed'(q_data));
			pg_s1 <= PROD_W'(gain_g_q) * PROD_W'(y_q);
		end
	end

	// Add, scale down and clamp
	assign sum    = SUM_W'(pa_s1) + SUM_W'(pg_s1);
	assign y_next = ftfi_pkg::sat_out(64'(sum >>> ftfi_pkg::IIR_SHIFT));

	// Update feedback and present the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q            <= '0;
			filtered.valid <= 1'b0;
		end else if (advance) begin
			y_q            <= y_next;
			filtered.valid <= 1'b1;
		end else if (filtered.ready) begin
			filtered.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			filtered.sample_out <= y_next;
		end
	end
endmodule
`default_nettype wire

// ===== sv/fir_then_first_order_iir_core.sv =====
// Top level of the FIR filter cascaded with a first-order recursive stage.
// Each sample passes a TAP_COUNT-tap FIR (Q4.12 weights, floor shift by 12, clamp to
// 20 bits) and then y = (a*x + g*y_prev) >> 15 with Q1.15 gains, clamped to 20 bits.
// The FIR front takes one sample per cycle while the queue has room; the recursive
// back takes a new item only once its feedback loop (a registered product pair, then
// the add and clamp that write y_prev) has stored the last result. An accepted sample
// passes the tap window, tap products, queue, recursive product pair and output register.
// Configuration writes go in through cfg_we/cfg_index/cfg_data at any edge; indexes 6 and 7 are ignored.
`default_nettype none
module fir_then_first_order_iir_core #(
	parameter int TAP_COUNT    = ftfi_pkg::TAP_COUNT_DEF,
	parameter int SAMPLE_WIDTH = ftfi_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ftfi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ftfi_pkg::CFG_DATA_W-1:0]   cfg_data,
	ftfi_in_if.sink                                raw,
	ftfi_out_if.source                             filtered
);
	ftfi_pkg::cfg_write_t               cfg;
	logic                               push;
	logic signed [ftfi_pkg::OUT_W-1:0]  push_data;
	logic                               pop;
	logic [ftfi_pkg::OUT_W-1:0]         pop_data;
	logic                               q_valid;
	logic [ftfi_pkg::QCNT_W-1:0]        q_count;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	ftfi_fir #(
		.TAP_COUNT    (TAP_COUNT),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_fir (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.raw       (raw),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	ftfi_queue #(
		.WIDTH (ftfi_pkg::OUT_W),
		.DEPTH (ftfi_pkg::QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_valid),
		.count     (q_count)
	);

	ftfi_iir u_iir (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_data   (pop_data),
		.pop      (pop),
		.filtered (filtered)
	);
endmodule
`default_nettype wire
